// File: rtl/core/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, register codes and constants for the scanline pixel unpacker.
// ----------------------------------------------------------------------------
package psu_pkg;

    localparam int COUNT_BITS = 16;
    localparam int DATA_W     = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int FIELD_W    = 16;
    localparam int CMP_W      = ((COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W) + 1;

    localparam logic [DATA_W-1:0] RED_BYTE_MASK = 32'h00ff0000;
    localparam logic [DATA_W-1:0] GRN_MASK      = 32'h0000ff00;
    localparam logic [DATA_W-1:0] BLU_MASK      = 32'h000000ff;
    localparam int                RED_SHIFT     = 20 - 16;
    localparam int                GRN_SHIFT     = 10 - 8;

    typedef enum logic [2:0] {
        REG_UNIT_BITS,
        REG_PIXEL_BITS,
        REG_MSB_FIRST,
        REG_RGB_PACK,
        REG_ROW_PIXELS,
        REG_ROW_WORDS,
        REG_ROW_COUNT
    } psu_reg_t;

    typedef struct packed {
        logic [5:0]         unit_bits;
        logic [5:0]         pixel_bits;
        logic               msb_first;
        logic               rgb_pack;
        logic [FIELD_W-1:0] row_pixels;
        logic [FIELD_W-1:0] row_words;
        logic [FIELD_W-1:0] row_count;
    } psu_cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] pixel;
        logic              last_in_word;
        logic              row_end;
        logic              image_end;
        logic              format_error;
    } psu_result_t;

    // red to bits 27:20, green to 17:10, blue stays in 7:0
    function automatic logic [DATA_W-1:0] repack(input logic [DATA_W-1:0] p);
        repack = ((p & RED_BYTE_MASK) << RED_SHIFT) + ((p & GRN_MASK) << GRN_SHIFT)
               + (p & BLU_MASK);
    endfunction

endpackage

// File: rtl/core/psu_cfg_regs.sv
// ----------------------------------------------------------------------------
// psu_cfg_regs
// APB-style register file holding the unpacker format and geometry setup.
// ----------------------------------------------------------------------------
module psu_cfg_regs
    import psu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    output psu_cfg_t              cfg
);

    psu_cfg_t cfg_reg;
    psu_cfg_t cfg_next;
    psu_reg_t sel;
    logic     wr_en;

    assign pready = 1'b1;
    assign sel    = psu_reg_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (sel)
                REG_UNIT_BITS:   cfg_next.unit_bits   = pwdata[5:0];
                REG_PIXEL_BITS:  cfg_next.pixel_bits  = pwdata[5:0];
                REG_MSB_FIRST:   cfg_next.msb_first   = pwdata[0];
                REG_RGB_PACK:    cfg_next.rgb_pack    = pwdata[0];
                REG_ROW_PIXELS:  cfg_next.row_pixels  = pwdata[FIELD_W-1:0];
                REG_ROW_WORDS:   cfg_next.row_words   = pwdata[FIELD_W-1:0];
                REG_ROW_COUNT:   cfg_next.row_count   = pwdata[FIELD_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_UNIT_BITS:   prdata = {{(DATA_W-6){1'b0}}, cfg_reg.unit_bits};
            REG_PIXEL_BITS:  prdata = {{(DATA_W-6){1'b0}}, cfg_reg.pixel_bits};
            REG_MSB_FIRST:   prdata = {{(DATA_W-1){1'b0}}, cfg_reg.msb_first};
            REG_RGB_PACK:    prdata = {{(DATA_W-1){1'b0}}, cfg_reg.rgb_pack};
            REG_ROW_PIXELS:  prdata = {{(DATA_W-FIELD_W){1'b0}}, cfg_reg.row_pixels};
            REG_ROW_WORDS:   prdata = {{(DATA_W-FIELD_W){1'b0}}, cfg_reg.row_words};
            REG_ROW_COUNT:   prdata = {{(DATA_W-FIELD_W){1'b0}}, cfg_reg.row_count};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.unit_bits   <= 6'd8;
            cfg_reg.pixel_bits  <= 6'd8;
            cfg_reg.msb_first   <= 1'b1;
            cfg_reg.rgb_pack    <= 1'b0;
            cfg_reg.row_pixels  <= FIELD_W'(640);
            cfg_reg.row_words   <= FIELD_W'(640);
            cfg_reg.row_count   <= FIELD_W'(480);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/psu_slicer.sv
// ----------------------------------------------------------------------------
// psu_slicer
// Holds one storage word and cuts one pixel from it per cycle while the
// output is not stalled, tracking column, word-in-row and row position.
// ----------------------------------------------------------------------------
module psu_slicer
    import psu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  psu_cfg_t          cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [DATA_W-1:0] s_word,
    input  logic              out_ready,
    output logic              emit,
    output psu_result_t       result
);

    logic                  in_valid_reg, in_valid_next;
    logic [DATA_W-1:0]     word_reg;
    logic [5:0]            k_reg, k_next;
    logic [COUNT_BITS-1:0] col_reg, col_next;
    logic [COUNT_BITS-1:0] wir_reg, wir_next;
    logic [COUNT_BITS-1:0] row_reg, row_next;

    logic                  unit_ok, fmt_ok;
    logic [2:0]            lg;
    logic [5:0]            per;
    logic [5:0]            off, off_last, sh, left;
    logic [DATA_W-1:0]     umask, pmask, raw;
    logic [COUNT_BITS-1:0] col_inc;
    logic [CMP_W-1:0]      col_ext, rp_ext;
    logic                  col_lt, re, short_row, last_word, last_row;
    logic                  can_emit, last, consume, row_done;

    always_comb begin
        case (cfg.pixel_bits)
            6'd1:    lg = 3'd0;
            6'd2:    lg = 3'd1;
            6'd4:    lg = 3'd2;
            6'd8:    lg = 3'd3;
            6'd16:   lg = 3'd4;
            6'd32:   lg = 3'd5;
            default: lg = 3'd0;
        endcase
    end

    always_comb begin
        case (cfg.unit_bits)
            6'd8:    umask = 32'h000000ff;
            6'd16:   umask = 32'h0000ffff;
            default: umask = 32'hffffffff;
        endcase
    end

    // a power-of-two pixel width no wider than the unit always divides it
    assign unit_ok = (cfg.unit_bits == 6'd8) || (cfg.unit_bits == 6'd16)
                  || (cfg.unit_bits == 6'd32);
    assign fmt_ok  = unit_ok && (cfg.pixel_bits != 6'd0)
                  && ((cfg.pixel_bits & (cfg.pixel_bits - 6'd1)) == 6'd0)
                  && (cfg.pixel_bits <= cfg.unit_bits);
    assign per     = cfg.unit_bits >> lg;
    assign pmask   = (cfg.pixel_bits >= 6'd32) ? '1
                   : ((DATA_W'(1) << cfg.pixel_bits) - DATA_W'(1));

    assign off      = k_reg << lg;
    assign off_last = (k_reg + 6'd1) << lg;
    assign sh       = cfg.msb_first ? (cfg.unit_bits - off_last) : off;
    assign raw      = ((word_reg & umask) >> sh) & pmask;

    assign col_inc   = col_reg + COUNT_BITS'(1);
    assign col_ext   = CMP_W'(col_reg);
    assign rp_ext    = CMP_W'(cfg.row_pixels);
    assign col_lt    = col_ext < rp_ext;
    assign re        = CMP_W'(col_inc) >= rp_ext;
    assign last_word = (CMP_W'(wir_reg) + CMP_W'(1)) >= CMP_W'(cfg.row_words);
    assign last_row  = (CMP_W'(row_reg) + CMP_W'(1)) >= CMP_W'(cfg.row_count);
    // column plus pixels still due stays fixed through the word
    assign left      = per - k_reg;
    assign short_row = last_word && ((col_ext + CMP_W'(left)) < rp_ext);

    assign can_emit = in_valid_reg && (!fmt_ok || ((k_reg < per) && col_lt));
    assign emit     = can_emit && out_ready;
    assign last     = !fmt_ok || ((7'(k_reg) + 7'd1) >= 7'(per)) || re;
    assign consume  = in_valid_reg && ((emit && last) || !can_emit);
    assign s_ready  = !in_valid_reg || consume;
    assign row_done = re || (short_row && last);

    always_comb begin
        if (!fmt_ok) begin
            result.pixel        = '0;
            result.last_in_word = 1'b1;
            result.row_end      = 1'b0;
            result.image_end    = 1'b0;
            result.format_error = 1'b1;
        end else begin
            result.pixel        = cfg.rgb_pack ? repack(raw) : raw;
            result.last_in_word = last;
            result.row_end      = row_done;
            result.image_end    = row_done && last_row;
            result.format_error = short_row;
        end
    end

    always_comb begin
        in_valid_next = (s_valid && s_ready) || (in_valid_reg && !consume);
        k_next        = consume ? 6'd0 : (emit ? k_reg + 6'd1 : k_reg);
        col_next      = col_reg;
        wir_next      = wir_reg;
        row_next      = row_reg;
        if (emit && fmt_ok) begin
            col_next = col_inc;
        end
        if (consume && fmt_ok) begin
            if (last_word) begin
                col_next = '0;
                wir_next = '0;
                row_next = last_row ? '0 : row_reg + COUNT_BITS'(1);
            end else begin
                wir_next = wir_reg + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            k_reg        <= '0;
            col_reg      <= '0;
            wir_reg      <= '0;
            row_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            k_reg        <= k_next;
            col_reg      <= col_next;
            wir_reg      <= wir_next;
            row_reg      <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_word;
        end
    end

`ifndef SYNTH
    a_emit_needs_word: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (in_valid_reg && out_ready))
        else $error("pixel cut with no word held or output stalled");

    a_idle_index_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> (k_reg == 6'd0))
        else $error("pixel index not cleared between words");

    a_bad_word_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fmt_ok && consume) |-> emit)
        else $error("bad-format word dropped without its error result");

    a_state_holds_on_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fmt_ok) |=> ($stable(col_reg) && $stable(wir_reg)
                                       && $stable(row_reg)))
        else $error("position moved on a bad-format word");
`endif

endmodule

// File: rtl/core/psu_out_stage.sv
// ----------------------------------------------------------------------------
// psu_out_stage
// Result register that decouples pixel cutting from the downstream consumer.
// ----------------------------------------------------------------------------
module psu_out_stage
    import psu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  psu_result_t       result,
    output logic              out_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_pixel,
    output logic              m_last_in_word,
    output logic              m_row_end,
    output logic              m_image_end,
    output logic              m_format_error
);

    logic        valid_reg, valid_next;
    psu_result_t data_reg;

    assign out_ready  = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid        = valid_reg;
    assign m_pixel        = data_reg.pixel;
    assign m_last_in_word = data_reg.last_in_word;
    assign m_row_end      = data_reg.row_end;
    assign m_image_end    = data_reg.image_end;
    assign m_format_error = data_reg.format_error;

endmodule

// File: rtl/core/packed_scanline_pixel_unpacker.sv
// ----------------------------------------------------------------------------
// packed_scanline_pixel_unpacker
// Cuts fixed-width pixels from packed scanline storage words, with optional
// direct-colour repacking and row/image position flags.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | s_word
//  m_      | out       | m_valid / m_ready | m_pixel, m_last_in_word, m_row_end,
//          |           |                   | m_image_end, m_format_error
//  apb     | in/out    | psel, penable     | paddr, pwdata, prdata, pready
//
// Each word is cut into its n pixels: up to 32 for 1-bit pixels in a 32-bit
// unit; padding words pass at one per cycle.
// The single shifter cuts one pixel per cycle while m_ready does not stall.
// Reset is synchronous; counters clear at once, no clearing pass.
// A stall on m_ready holds the result register and the word being cut.
// ----------------------------------------------------------------------------
module packed_scanline_pixel_unpacker
    import psu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DATA_W-1:0]     s_word,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_W-1:0]     m_pixel,
    output logic                  m_last_in_word,
    output logic                  m_row_end,
    output logic                  m_image_end,
    output logic                  m_format_error
);

    psu_cfg_t    cfg;
    psu_result_t result;
    logic        emit;
    logic        out_ready;

    psu_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psu_slicer u_slicer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .out_ready (out_ready),
        .emit      (emit),
        .result    (result)
    );

    psu_out_stage u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (emit),
        .result         (result),
        .out_ready      (out_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel        (m_pixel),
        .m_last_in_word (m_last_in_word),
        .m_row_end      (m_row_end),
        .m_image_end    (m_image_end),
        .m_format_error (m_format_error)
    );

endmodule
